>>> rtl/lfcsl_pkg.sv
// Package for the front clearance speed limiter: item types, codes,
// register indexes, reset values and serial unit widths. No dependencies.
package lfcsl_pkg;

    // item kinds
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_VEL    = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // zone codes
    localparam logic [1:0] ZONE_CLEAR = 2'd0;
    localparam logic [1:0] ZONE_SLOW  = 2'd1;
    localparam logic [1:0] ZONE_STOP  = 2'd2;

    // config port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STOP_DIST  = 3'd0,
        REG_SLOW_DIST  = 3'd1,
        REG_CONE_HALF  = 3'd2,
        REG_START_ANG  = 3'd3,
        REG_ANG_STEP   = 3'd4,
        REG_RANGE_MIN  = 3'd5,
        REG_RANGE_MAX  = 3'd6
    } cfg_reg_t;

    localparam logic [15:0]        STOP_DIST_RST = 16'd350;
    localparam logic [15:0]        SLOW_DIST_RST = 16'd750;
    localparam logic [18:0]        CONE_HALF_RST = 19'd51472;
    localparam logic signed [19:0] START_ANG_RST = -20'sd205887;
    localparam logic [16:0]        ANG_STEP_RST  = 17'd1144;
    localparam logic [15:0]        RANGE_MIN_RST = 16'd0;
    localparam logic [15:0]        RANGE_MAX_RST = 16'hFFFF;

    // serial multiplier: 17-bit multiplicand, 16-bit multiplier, one bit per cycle
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // serial divider: 32-bit dividend, 16-bit divisor and quotient
    localparam int DIV_W = 16;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [11:0]        sample_index;
        logic [15:0]        range_mm;
        logic               range_finite;
        logic               scan_last;
        logic signed [15:0] lin_vel_in;
        logic signed [15:0] ang_vel_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] lin_vel_out;
        logic signed [15:0] ang_vel_out;
        logic [1:0]         zone;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ANG_MUL,
        S_VEL_MUL,
        S_VEL_DIV,
        S_EMIT
    } state_t;

endpackage

>>> rtl/lidar_front_clearance_speed_limiter_unit.sv
// Front clearance speed limiter, top level. Uses lfcsl_pkg, lfcsl_seq_mul, lfcsl_seq_div.
// Takes one beat at a time; in_ready is high only in idle. A velocity command, or a tick with
// no command held, is absorbed in idle; a scan sample runs the serial angle multiply; a tick
// goes to the emit step, a slowing-zone tick through the serial multiply and then the serial
// divide before emit. A tick waits in its last step while the previous result is unaccepted.
// Reset (rst_n, async low) loads register defaults, clears scan state.
module lidar_front_clearance_speed_limiter_unit
    import lfcsl_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input beats
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    // result beats
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        stop_reg;
    logic [15:0]        slow_reg;
    logic [18:0]        cone_reg;
    logic signed [19:0] start_ang_reg;
    logic [16:0]        step_reg;
    logic [15:0]        rmin_reg;
    logic [15:0]        rmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg      <= STOP_DIST_RST;
            slow_reg      <= SLOW_DIST_RST;
            cone_reg      <= CONE_HALF_RST;
            start_ang_reg <= START_ANG_RST;
            step_reg      <= ANG_STEP_RST;
            rmin_reg      <= RANGE_MIN_RST;
            rmax_reg      <= RANGE_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_STOP_DIST: stop_reg      <= cfg_wdata[15:0];
                REG_SLOW_DIST: slow_reg      <= cfg_wdata[15:0];
                REG_CONE_HALF: cone_reg      <= cfg_wdata[18:0];
                REG_START_ANG: start_ang_reg <= signed'(cfg_wdata[19:0]);
                REG_ANG_STEP:  step_reg      <= cfg_wdata[16:0];
                REG_RANGE_MIN: rmin_reg      <= cfg_wdata[15:0];
                REG_RANGE_MAX: rmax_reg      <= cfg_wdata[15:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    // scan tracking
    logic [15:0] min_reg, min_next;
    logic        hit_reg, hit_next;
    logic [15:0] clear_reg, clear_next;
    logic        known_reg, known_next;
    // held command
    logic signed [15:0] hlin_reg, hlin_next;
    logic signed [15:0] hang_reg, hang_next;
    logic               have_cmd_reg, have_cmd_next;
    // sample waiting on its angle
    logic        smp_ok_reg, smp_ok_next;
    logic        smp_last_reg, smp_last_next;
    logic [15:0] smp_range_reg, smp_range_next;
    // pending result
    logic [15:0] res_lin_reg, res_lin_next;
    logic [1:0]  res_zone_reg, res_zone_next;
    logic        neg_reg, neg_next;
    // output register
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // Decode of the incoming beat and of the zone
    // ------------------------------------------------------------------
    logic in_fire;
    logic is_sample, is_vel, is_tick;
    logic idx_ok, range_ok;
    logic tick_stop, tick_slow;
    logic out_free;

    assign in_fire   = in_valid && in_ready;
    assign is_sample = (in_data.cmd == CMD_SAMPLE);
    assign is_vel    = (in_data.cmd == CMD_VEL);
    assign is_tick   = (in_data.cmd == CMD_TICK);

    assign idx_ok   = (32'(in_data.sample_index) < 32'(MAX_SAMPLES));
    assign range_ok = in_data.range_finite
                   && (in_data.range_mm >= rmin_reg)
                   && (in_data.range_mm <= rmax_reg);

    // stop test wins over the slowing band
    assign tick_stop = known_reg && (clear_reg <= stop_reg);
    assign tick_slow = known_reg && !tick_stop && (clear_reg <= slow_reg);

    assign out_free = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------
    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_den;
    logic [DIV_W-1:0]   div_q;
    logic [15:0]        lin_mag;
    logic [15:0]        clear_excess;

    // |lin| fits 16 bits unsigned, including the most negative value
    assign lin_mag      = hlin_reg[15] ? 16'(~hlin_reg + 16'sd1) : hlin_reg;
    assign clear_excess = clear_reg - stop_reg;
    assign div_den      = slow_reg - stop_reg;

    // angle for samples (step * index), (clear - stop) * |lin| for ticks
    assign mul_a = is_sample ? step_reg : {1'b0, clear_excess};
    assign mul_b = is_sample ? MUL_B_W'(in_data.sample_index) : lin_mag;

    lfcsl_seq_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .prod   (mul_p)
    );

    // product <= 32768 * divisor, so the divider precondition holds
    lfcsl_seq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_p[2*DIV_W-1:0]),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // angle = start + index * step; index * step stays below 2^29
    logic signed [MUL_P_W:0] angle;
    logic signed [MUL_P_W:0] cone_pos;
    logic                    in_cone;
    logic                    hit_now;

    assign angle    = (MUL_P_W+1)'(start_ang_reg) + signed'({1'b0, mul_p});
    assign cone_pos = signed'((MUL_P_W+1)'(cone_reg));
    assign in_cone  = (angle <= cone_pos) && (angle >= -cone_pos);
    assign hit_now  = smp_ok_reg && in_cone;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (is_sample)
                        state_next = S_ANG_MUL;
                    else if (is_tick && have_cmd_reg)
                        state_next = tick_slow ? S_VEL_MUL : S_EMIT;
                    else
                        state_next = S_IDLE;
                end
            end
            S_ANG_MUL: if (mul_done) state_next = S_IDLE;
            S_VEL_MUL: if (mul_done) state_next = S_VEL_DIV;
            S_VEL_DIV: if (div_done) state_next = S_EMIT;
            S_EMIT:    if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs
    // ------------------------------------------------------------------
    logic out_load;

    always_comb
    begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                mul_start = in_valid && (is_sample || (is_tick && have_cmd_reg && tick_slow));
            end
            S_ANG_MUL: ;
            S_VEL_MUL: div_start = mul_done;
            S_VEL_DIV: ;
            S_EMIT:    out_load  = out_free;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    logic [15:0] min_upd;
    logic        hit_upd;

    assign min_upd = (hit_now && (smp_range_reg < min_reg)) ? smp_range_reg : min_reg;
    assign hit_upd = hit_reg || hit_now;

    always_comb
    begin
        min_next       = min_reg;
        hit_next       = hit_reg;
        clear_next     = clear_reg;
        known_next     = known_reg;
        hlin_next      = hlin_reg;
        hang_next      = hang_reg;
        have_cmd_next  = have_cmd_reg;
        smp_ok_next    = smp_ok_reg;
        smp_last_next  = smp_last_reg;
        smp_range_next = smp_range_reg;
        res_lin_next   = res_lin_reg;
        res_zone_next  = res_zone_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (state_reg == S_IDLE && in_fire)
        begin
            if (is_sample)
            begin
                smp_ok_next    = idx_ok && range_ok;
                smp_last_next  = in_data.scan_last;
                smp_range_next = in_data.range_mm;
            end
            if (is_vel)
            begin
                hlin_next     = in_data.lin_vel_in;
                hang_next     = in_data.ang_vel_in;
                have_cmd_next = 1'b1;
            end
            if (is_tick)
            begin
                neg_next = hlin_reg[15];
                priority if (tick_stop)
                begin
                    res_lin_next  = '0;
                    res_zone_next = ZONE_STOP;
                end
                else if (tick_slow)
                    res_zone_next = ZONE_SLOW;
                else
                begin
                    res_lin_next  = hlin_reg;
                    res_zone_next = ZONE_CLEAR;
                end
            end
        end

        // sample angle is ready: fold into running minimum, close scan on last
        if (state_reg == S_ANG_MUL && mul_done)
        begin
            if (smp_last_reg)
            begin
                if (hit_upd)
                begin
                    clear_next = min_upd;
                    known_next = 1'b1;
                end
                min_next = 16'hFFFF;
                hit_next = 1'b0;
            end
            else
            begin
                min_next = min_upd;
                hit_next = hit_upd;
            end
        end

        // truncation toward zero: divide magnitudes, restore sign
        if (state_reg == S_VEL_DIV && div_done)
            res_lin_next = neg_reg ? 16'(~div_q + 1'b1) : div_q;

        if (out_load)
        begin
            out_valid_next            = 1'b1;
            out_data_next.lin_vel_out = res_lin_reg;
            out_data_next.ang_vel_out = (res_zone_reg == ZONE_STOP) ? 16'sd0 : hang_reg;
            out_data_next.zone        = res_zone_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_reg       <= 16'hFFFF;
            hit_reg       <= 1'b0;
            clear_reg     <= '0;
            known_reg     <= 1'b0;
            hlin_reg      <= '0;
            hang_reg      <= '0;
            have_cmd_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            hit_reg       <= hit_next;
            clear_reg     <= clear_next;
            known_reg     <= known_next;
            hlin_reg      <= hlin_next;
            hang_reg      <= hang_next;
            have_cmd_reg  <= have_cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        smp_ok_reg    <= smp_ok_next;
        smp_last_reg  <= smp_last_next;
        smp_range_reg <= smp_range_next;
        res_lin_reg   <= res_lin_next;
        res_zone_reg  <= res_zone_next;
        neg_reg       <= neg_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/lfcsl_seq_mul.sv
// Bit-serial shift-add multiplier, unsigned, one multiplier bit per cycle.
// Depends on lfcsl_pkg for operand widths.
module lfcsl_seq_mul
    import lfcsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] mcand,
    input  logic [MUL_B_W-1:0] mplier,
    output logic               done,
    output logic [MUL_P_W-1:0] prod
);

    localparam int CNT_W = $clog2(MUL_B_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MUL_A_W-1:0] mcand_reg, mcand_next;
    logic [MUL_P_W-1:0] prod_reg, prod_next;
    logic [MUL_A_W:0]   sum;

    // partial sum on the upper half, then shift right one place
    assign sum = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
               + (prod_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = mcand;
            prod_next  = {{MUL_A_W{1'b0}}, mplier};
        end
        else if (busy_reg)
        begin
            prod_next = {sum, prod_reg[MUL_B_W-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

>>> rtl/lfcsl_seq_div.sv
// Restoring divider, unsigned, one quotient bit per cycle.
// Depends on lfcsl_pkg. Needs dividend[31:16] < divisor.
module lfcsl_seq_div
    import lfcsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2*DIV_W-1:0] num,
    input  logic [DIV_W-1:0]   den,
    output logic               done,
    output logic [DIV_W-1:0]   quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] low_reg, low_next;   // dividend bits out, quotient bits in
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, low_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = den;
            rem_next  = num[2*DIV_W-1:DIV_W];
            low_next  = num[DIV_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            low_next = {low_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

>>> verif/lidar_front_clearance_speed_limiter_unit_test.sv
// Self-checking bench for lidar_front_clearance_speed_limiter_unit: scan filtering,
// clearance tracking and speed limiting, checked beat by beat against a local model.
// Depends on lfcsl_pkg and the RTL only.
module lidar_front_clearance_speed_limiter_unit_test;
    import lfcsl_pkg::*;

    // cmd value the block must ignore; the package has no name for it
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_SAMPLES    = 4096;
    // longest path is a slowing tick; leave margin after the last beat
    localparam int SETTLE_CYCLES  = 48;
    // cycles with no beat on either channel before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [15:0]        stop_mm;
        logic [15:0]        slow_mm;
        logic [18:0]        cone_half;
        logic signed [19:0] start_ang;
        logic [16:0]        ang_step;
        logic [15:0]        rng_floor;
        logic [15:0]        rng_ceil;
    } limiter_cfg_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;

    lidar_front_clearance_speed_limiter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Model state: register copy plus the block's scan/command state
    // ---------------------------------------------------------------
    limiter_cfg_t       mcfg;
    logic [15:0]        min_run_mm;
    bit                 scan_hit;
    logic [15:0]        clear_mm;
    bit                 clear_valid;
    logic signed [15:0] cmd_lin;
    logic signed [15:0] cmd_ang;
    bit                 cmd_held;

    // limited commands still owed by the block, oldest first
    out_item_t limited_cmd_q[$];

    bit idle_en = 1'b1;   // random gaps/stalls on both channels
    int scan_lo, scan_hi; // range of scan start indexes that reaches the cone
    int items_sent;
    int results_seen;
    int cfg_loads;
    int err_count;

    function automatic limiter_cfg_t reset_cfg();
        limiter_cfg_t c;
        c.stop_mm   = STOP_DIST_RST;
        c.slow_mm   = SLOW_DIST_RST;
        c.cone_half = CONE_HALF_RST;
        c.start_ang = START_ANG_RST;
        c.ang_step  = ANG_STEP_RST;
        c.rng_floor = RANGE_MIN_RST;
        c.rng_ceil  = RANGE_MAX_RST;
        return c;
    endfunction

    function automatic limiter_cfg_t make_cfg(int stop, int slow, int cone, int start,
                                              int step, int floor_mm, int ceil_mm);
        limiter_cfg_t c;
        c.stop_mm   = 16'(stop);
        c.slow_mm   = 16'(slow);
        c.cone_half = 19'(cone);
        c.start_ang = 20'(start);
        c.ang_step  = 17'(step);
        c.rng_floor = 16'(floor_mm);
        c.rng_ceil  = 16'(ceil_mm);
        return c;
    endfunction

    // Advance the model by one accepted beat; returns 1 when a result is owed.
    function automatic bit limit_speed(input in_item_t it, output out_item_t res);
        longint             angle;
        longint             mag;
        longint             num;
        longint             den;
        longint             quo;
        logic signed [15:0] lin;
        logic signed [15:0] ang;
        logic [1:0]         zone;
        res = '0;
        case (it.cmd)
            CMD_SAMPLE:
            begin
                if (int'(it.sample_index) < NUM_SAMPLES)
                begin
                    // exact angle, no wrap
                    angle = longint'(mcfg.start_ang)
                          + longint'(it.sample_index) * longint'(mcfg.ang_step);
                    mag = (angle < 0) ? -angle : angle;
                    if (mag <= longint'(mcfg.cone_half) && it.range_finite &&
                        it.range_mm >= mcfg.rng_floor && it.range_mm <= mcfg.rng_ceil)
                    begin
                        if (it.range_mm < min_run_mm)
                            min_run_mm = it.range_mm;
                        scan_hit = 1'b1;
                    end
                end
                // end of scan: publish minimum only if something was kept
                if (it.scan_last)
                begin
                    if (scan_hit)
                    begin
                        clear_mm    = min_run_mm;
                        clear_valid = 1'b1;
                    end
                    min_run_mm = 16'hFFFF;
                    scan_hit   = 1'b0;
                end
                return 1'b0;
            end
            CMD_VEL:
            begin
                cmd_lin  = it.lin_vel_in;
                cmd_ang  = it.ang_vel_in;
                cmd_held = 1'b1;
                return 1'b0;
            end
            CMD_TICK:
            begin
                if (!cmd_held)
                    return 1'b0;
                lin  = cmd_lin;
                ang  = cmd_ang;
                zone = ZONE_CLEAR;
                if (clear_valid)
                begin
                    // stop test wins over slowing
                    if (clear_mm <= mcfg.stop_mm)
                    begin
                        lin  = '0;
                        ang  = '0;
                        zone = ZONE_STOP;
                    end
                    else if (clear_mm <= mcfg.slow_mm)
                    begin
                        num  = longint'(cmd_lin) * (longint'(clear_mm) - longint'(mcfg.stop_mm));
                        den  = longint'(mcfg.slow_mm) - longint'(mcfg.stop_mm);
                        quo  = num / den;   // truncates toward zero
                        lin  = quo[15:0];
                        zone = ZONE_SLOW;
                    end
                end
                res.lin_vel_out = lin;
                res.ang_vel_out = ang;
                res.zone        = zone;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void reset_model();
        mcfg        = reset_cfg();
        min_run_mm  = 16'hFFFF;
        scan_hit    = 1'b0;
        clear_mm    = '0;
        clear_valid = 1'b0;
        cmd_lin     = '0;
        cmd_ang     = '0;
        cmd_held    = 1'b0;
    endfunction

    // Range picker biased toward the stop and slow bands of the current setting.
    function automatic logic [15:0] pick_range();
        int sel;
        int lo;
        int hi;
        sel = $urandom_range(0, 4);
        case (sel)
            0: return 16'($urandom_range(0, int'(mcfg.stop_mm)));
            1:
            begin
                lo = int'(mcfg.stop_mm);
                hi = int'(mcfg.slow_mm);
                if (hi < lo)
                    hi = lo;
                return 16'($urandom_range(lo, hi));
            end
            2:
            begin
                hi = int'(mcfg.slow_mm) + 2000;
                if (hi > 65535)
                    hi = 65535;
                return 16'($urandom_range(0, hi));
            end
            default: return 16'($urandom());
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Input side. Valid stays up across back-to-back beats; it drops
    // only for a gap or when a phase settles.
    // ---------------------------------------------------------------
    task automatic send_beat(in_item_t it);
        out_item_t res;
        int        gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        // beat taken at this edge
        if (limit_speed(it, res))
            limited_cmd_q.push_back(res);
        if (it.cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_sample(logic [11:0] idx, logic [15:0] rng, bit fin, bit last);
        in_item_t it;
        it = {$urandom(), $urandom()};   // unused fields stay random
        it.cmd          = CMD_SAMPLE;
        it.sample_index = idx;
        it.range_mm     = rng;
        it.range_finite = fin;
        it.scan_last    = last;
        send_beat(it);
    endtask

    task automatic send_vel(logic signed [15:0] lin, logic signed [15:0] ang);
        in_item_t it;
        it = {$urandom(), $urandom()};
        it.cmd        = CMD_VEL;
        it.lin_vel_in = lin;
        it.ang_vel_in = ang;
        send_beat(it);
    endtask

    task automatic send_tick();
        in_item_t it;
        it = {$urandom(), $urandom()};
        it.cmd = CMD_TICK;
        send_beat(it);
    endtask

    task automatic send_unused();
        in_item_t it;
        it = {$urandom(), $urandom()};
        it.cmd = CMD_UNUSED;
        send_beat(it);
    endtask

    // One scan of consecutive indexes around the cone; now and then the
    // end mark is dropped so the scan runs into the next one.
    task automatic send_scan();
        int base;
        int len;
        int idx;
        bit drop_last;
        base      = $urandom_range(scan_lo, scan_hi);
        len       = $urandom_range(3, 20);
        drop_last = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++)
        begin
            idx = base + i;
            if (idx > NUM_SAMPLES - 1)
                idx = NUM_SAMPLES - 1;
            send_sample(12'(idx), pick_range(), $urandom_range(0, 9) != 0,
                        (i == len - 1) && !drop_last);
        end
    endtask

    // Wait for every owed result, then for the block to finish any sample
    // still in flight, so registers can be rewritten safely.
    task automatic settle();
        in_valid <= 1'b0;
        while (limited_cmd_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all seven registers on consecutive edges; call only when settled.
    task automatic load_config(limiter_cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_STOP_DIST;
        cfg_wdata <= CFG_DATA_W'(c.stop_mm);
        @(posedge clk);
        cfg_addr  <= REG_SLOW_DIST;
        cfg_wdata <= CFG_DATA_W'(c.slow_mm);
        @(posedge clk);
        cfg_addr  <= REG_CONE_HALF;
        cfg_wdata <= CFG_DATA_W'(c.cone_half);
        @(posedge clk);
        cfg_addr  <= REG_START_ANG;
        cfg_wdata <= c.start_ang;
        @(posedge clk);
        cfg_addr  <= REG_ANG_STEP;
        cfg_wdata <= CFG_DATA_W'(c.ang_step);
        @(posedge clk);
        cfg_addr  <= REG_RANGE_MIN;
        cfg_wdata <= CFG_DATA_W'(c.rng_floor);
        @(posedge clk);
        cfg_addr  <= REG_RANGE_MAX;
        cfg_wdata <= CFG_DATA_W'(c.rng_ceil);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mcfg = c;
        cfg_loads++;
    endtask

    // Random mix: mostly well-formed scans, commands and ticks, some noise.
    task automatic run_traffic(int n_items);
        int target;
        int pick;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_scan();
            else if (pick < 58)
                send_vel(16'($urandom()), 16'($urandom()));
            else if (pick < 88)
                send_tick();
            else
                send_beat({$urandom(), $urandom()});
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset register values: tick before any command, unknown clearance,
    // then a close hit that stops the robot.
    task automatic test_reset_defaults();
        send_tick();                          // no command held: no result
        send_vel(16'sd32767, 16'sh8000);
        send_tick();                          // clearance unknown: pass through
        send_sample(12'd180, 16'd300, 1'b1, 1'b1);
        send_tick();                          // 300 <= 350: stop
        settle();
    endtask

    // Sample rejection paths, a scan with no kept sample, cone edges,
    // truncation of a negative scaled speed, and the ignored kind.
    task automatic test_sample_filter();
        // cone covers indexes 6..14
        load_config(make_cfg(100, 1100, 4000, -10000, 1000, 50, 60000));
        send_sample(12'd0, 16'd10, 1'b1, 1'b0);      // outside cone
        send_sample(12'd10, 16'd49, 1'b1, 1'b0);     // below floor
        send_sample(12'd10, 16'd60001, 1'b1, 1'b0);  // above ceiling
        send_sample(12'd11, 16'd20, 1'b0, 1'b0);     // not finite
        send_sample(12'd4095, 16'd0, 1'b1, 1'b1);    // end of scan, nothing kept
        send_vel(16'sh8000, 16'sd32767);
        send_tick();                                 // old 300 now in slow band
        send_sample(12'd6, 16'd600, 1'b1, 1'b0);     // cone edge, negative side
        send_sample(12'd14, 16'd1100, 1'b1, 1'b1);   // cone edge, positive side
        send_tick();
        send_unused();
        send_sample(12'd12, 16'd101, 1'b1, 1'b1);
        send_tick();                                 // -32.768 truncates to -32
        settle();
    endtask

    // Extreme register values: stop at or above slow, full-range angles,
    // zero step and zero cone.
    task automatic test_register_extremes();
        load_config(make_cfg(65535, 0, 262144, -262144, 65536, 0, 65535));
        send_sample(12'd8, 16'd65535, 1'b1, 1'b1);   // angle lands on +cone
        send_tick();
        settle();
        load_config(make_cfg(0, 65535, 262144, 262144, 0, 0, 65535));
        send_tick();                                 // full slow band, ratio 1
        send_sample(12'd4095, 16'd0, 1'b1, 1'b1);
        send_tick();                                 // clearance 0 at stop 0
        settle();
        load_config(make_cfg(0, 65535, 0, 0, 0, 0, 65535));
        send_sample(12'd0, 16'd7, 1'b1, 1'b1);
        send_tick();
        settle();
    endtask

    task automatic test_traffic_fixed_geometry();
        // cone covers indexes 12..28
        load_config(make_cfg(300, 1500, 8000, -20000, 1000, 20, 40000));
        scan_lo = 0;
        scan_hi = 24;
        run_traffic(150);
        settle();
    endtask

    task automatic test_traffic_random_limits();
        int k;
        int step;
        for (int n = 0; n < 2; n++)
        begin
            k    = $urandom_range(5, 30);
            step = $urandom_range(1, 4000);
            load_config(make_cfg($urandom_range(0, 2000), $urandom_range(0, 3000),
                                 $urandom_range(0, 10 * step), -k * step, step,
                                 $urandom_range(0, 100), $urandom_range(20000, 65535)));
            scan_lo = 0;
            scan_hi = k + 5;
            run_traffic(75);
            settle();
        end
    endtask

    // Last stretch: both channels run flat out.
    task automatic test_traffic_no_idle();
        idle_en = 1'b0;
        load_config(make_cfg(500, 900, 5000, -15000, 750, 0, 65535));
        scan_lo = 0;
        scan_hi = 30;
        run_traffic(150);
        settle();
    endtask

    // ---------------------------------------------------------------
    // Result side: check each beat, then pick next cycle's ready.
    // ---------------------------------------------------------------
    initial
    begin : result_check
        int        stall_left;
        out_item_t want;
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                results_seen++;
                if (limited_cmd_q.size() == 0)
                begin
                    $error("result beat with nothing pending: lin %0d ang %0d zone %0d",
                           out_data.lin_vel_out, out_data.ang_vel_out, out_data.zone);
                    err_count++;
                end
                else
                begin
                    want = limited_cmd_q.pop_front();
                    if (out_data.lin_vel_out !== want.lin_vel_out)
                    begin
                        $error("lin_vel_out: expected %0d, got %0d",
                               want.lin_vel_out, out_data.lin_vel_out);
                        err_count++;
                    end
                    if (out_data.ang_vel_out !== want.ang_vel_out)
                    begin
                        $error("ang_vel_out: expected %0d, got %0d",
                               want.ang_vel_out, out_data.ang_vel_out);
                        err_count++;
                    end
                    if (out_data.zone !== want.zone)
                    begin
                        $error("zone: expected %0d, got %0d", want.zone, out_data.zone);
                        err_count++;
                    end
                end
            end
            // random stall bursts, only while idle_en is set
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Hang detector: too long without a beat on either channel.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d results pending", limited_cmd_q.size());
            $display("lidar_front_clearance_speed_limiter_unit_test: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_sample_filter();
        test_register_extremes();
        test_traffic_fixed_geometry();
        test_traffic_random_limits();
        test_traffic_no_idle();

        $display("run covered %0d input beats and %0d checked results", items_sent,
                 results_seen);
        $display("across %0d register settings plus reset values", cfg_loads);
        if (err_count == 0)
            $display("lidar_front_clearance_speed_limiter_unit_test: clean");
        else
            $display("lidar_front_clearance_speed_limiter_unit_test: errors");
        $finish;
    end

endmodule
